>>> src/brb_pkg.sv
package brb_pkg;

  // Field widths of one input word and one result word.
  localparam int OpW   = 3;
  localparam int DataW = 16;
  localparam int OffW  = 10;
  localparam int LenW  = 11;
  localparam int SeedW = 16;
  localparam int ValW  = 32;
  localparam int CntW  = 10;
  localparam int SizeW = 11;
  // Window position: offset plus length minus one.
  localparam int PosW  = 12;

  typedef enum logic [2:0] {
    OP_PUT8  = 3'd0,
    OP_PUT16 = 3'd1,
    OP_POP8  = 3'd2,
    OP_POP16 = 3'd3,
    OP_POP32 = 3'd4,
    OP_PEEK  = 3'd5,
    OP_CRC   = 3'd6,
    OP_CLEAR = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT_HI,
    ST_PUT_LO,
    ST_POP,
    ST_LOOK,
    ST_DRAIN,
    ST_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch the accepted word
    logic clear;    // zero both indices
    logic wr_hi;    // write data[15:8] at the write index
    logic wr_lo;    // write data[7:0] at the write index
    logic pop_rd;   // read at the read index, advance it
    logic look_rd;  // read at read index + window position, step the window
    logic finish;   // load the output register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_look;  // one window byte left
    logic out_free;   // output register can take a result this cycle
  } sts_t;

  // x^k * 0x1021 for each bit k of the byte, index 7 first.
  localparam logic [7:0][15:0] CrcTerms = {
    16'h9188, 16'h48C4, 16'h2462, 16'h1231,
    16'h8108, 16'h4084, 16'h2042, 16'h1021
  };

  localparam logic [7:0] PadByte = 8'hFF;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [7:0]  x;
    logic [15:0] tab;
    x   = b ^ crc[15:8];
    tab = '0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) begin
        tab = tab ^ CrcTerms[k];
      end
    end
    return {crc[7:0] ^ tab[15:8], tab[7:0]};
  endfunction

endpackage

>>> src/brb_in_if.sv
interface brb_in_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::OpW-1:0]   op;
  logic [brb_pkg::DataW-1:0] data;
  logic [brb_pkg::OffW-1:0]  offset;
  logic [brb_pkg::LenW-1:0]  length;
  logic [brb_pkg::SeedW-1:0] crc_seed;

  modport source (output valid, op, data, offset, length, crc_seed, input ready);
  modport sink (input valid, op, data, offset, length, crc_seed, output ready);
endinterface

>>> src/brb_out_if.sv
interface brb_out_if;
  logic                      valid;
  logic                      ready;
  logic [brb_pkg::ValW-1:0] value;
  logic                      value_valid;
  logic [brb_pkg::CntW-1:0] held_count;

  modport source (output valid, value, value_valid, held_count, input ready);
  modport sink (input valid, value, value_valid, held_count, output ready);
endinterface

>>> src/byte_ring_buffer_with_crc.sv
// Byte ring buffer with a windowed CRC-16. Each input word is one operation:
// put8, put16 (high byte first), pop8/pop16/pop32 (big-endian), peek at an
// offset from the read index, clear, or CRC-16 (poly 0x1021, seed from the
// word) over a window of held bytes, walked from its last byte to its first;
// window bytes at or beyond the held count enter as 0xFF. Every result word
// carries the held count after the operation. There is no overflow guard:
// puts overwrite, a full ring reads as empty, and popping an empty ring just
// returns whatever the store holds at the read index. Writing ring_size
// (clamped to 1..STORE_DEPTH) also clears both indices; write it only while
// the block is idle. The store has no reset and no clearing pass, so the
// block takes words right after reset; reading a byte never written returns
// garbage. The store has a single registered read port (one byte a cycle),
// and the CRC advances one byte at a time. A finished result sits in an
// output register, so the next word is taken while the previous result
// waits.
module byte_ring_buffer_with_crc #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [brb_pkg::SizeW-1:0] cfg_wdata_i,
  brb_in_if.sink                    in_i,
  brb_out_if.source                 out_o
);
  import brb_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  // Sequencer: one operation at a time, steps the store port.
  brb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .op_i       (in_i.op),
    .len_zero_i (in_i.length == '0),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Indices, store, CRC and byte accumulator, output register.
  brb_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (in_i.op),
    .data_i        (in_i.data),
    .offset_i      (in_i.offset),
    .length_i      (in_i.length),
    .crc_seed_i    (in_i.crc_seed),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .value_o       (out_o.value),
    .value_valid_o (out_o.value_valid),
    .held_count_o  (out_o.held_count)
  );

  assign in_i.ready = in_ready;

endmodule

>>> src/brb_ram.sv
module brb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/brb_ctrl.sv
module brb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [brb_pkg::OpW-1:0] op_i,
  input  logic                   len_zero_i,
  input  brb_pkg::sts_t          sts_i,
  output brb_pkg::ctl_t          ctl_o
);
  import brb_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] nleft_q, nleft_d;  // pop bytes still to issue, minus one

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nleft_q <= '0;
    end else begin
      state_q <= state_d;
      nleft_q <= nleft_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    nleft_d    = nleft_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_PUT_HI: begin
        ctl_o.wr_hi = 1'b1;
        state_d     = ST_PUT_LO;
      end
      ST_PUT_LO: begin
        ctl_o.wr_lo = 1'b1;
        state_d     = ST_FIN;
      end
      ST_POP: begin
        ctl_o.pop_rd = 1'b1;
        if (nleft_q == 2'd0) begin
          state_d = ST_DRAIN;
        end else begin
          nleft_d = nleft_q - 2'd1;
        end
      end
      ST_LOOK: begin
        ctl_o.look_rd = 1'b1;
        if (sts_i.last_look) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read byte lands in the datapath this cycle
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.finish = 1'b1;
          in_ready_o   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (in_valid_i && in_ready_o) begin
      ctl_o.load = 1'b1;
      unique case (op_e'(op_i))
        OP_PUT8:  state_d = ST_PUT_LO;
        OP_PUT16: state_d = ST_PUT_HI;
        OP_POP8: begin
          state_d = ST_POP;
          nleft_d = 2'd0;
        end
        OP_POP16: begin
          state_d = ST_POP;
          nleft_d = 2'd1;
        end
        OP_POP32: begin
          state_d = ST_POP;
          nleft_d = 2'd3;
        end
        OP_PEEK:  state_d = ST_LOOK;
        OP_CRC:   state_d = len_zero_i ? ST_FIN : ST_LOOK;
        OP_CLEAR: begin
          ctl_o.clear = 1'b1;
          state_d     = ST_FIN;
        end
      endcase
    end
  end

endmodule

>>> src/brb_dp.sv
module brb_dp #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [brb_pkg::SizeW-1:0]  cfg_wdata_i,
  input  logic [brb_pkg::OpW-1:0]    op_i,
  input  logic [brb_pkg::DataW-1:0]  data_i,
  input  logic [brb_pkg::OffW-1:0]   offset_i,
  input  logic [brb_pkg::LenW-1:0]   length_i,
  input  logic [brb_pkg::SeedW-1:0]  crc_seed_i,
  input  brb_pkg::ctl_t              ctl_i,
  output brb_pkg::sts_t              sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [brb_pkg::ValW-1:0]   value_o,
  output logic                       value_valid_o,
  output logic [brb_pkg::CntW-1:0]   held_count_o
);
  import brb_pkg::*;

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int RW = $clog2(STORE_DEPTH + 1);
  localparam int CW = (RW > PosW) ? RW : PosW;
  localparam int SW = CW + 1;
  localparam int ResetSize = (STORE_DEPTH < 1024) ? STORE_DEPTH : 1024;

  // control state
  logic [IW-1:0] wr_idx_q, rd_idx_q;
  logic [RW-1:0] size_q;
  logic          pend_q, rng_q, out_valid_q;
  // payload
  op_e             op_q;
  logic [DataW-1:0] data_q;
  logic [PosW-1:0]  pos_q;
  logic [LenW-1:0]  cnt_q;
  logic [15:0]      crc_q;
  logic [ValW-1:0]  acc_q;
  logic             pk_ok_q;
  logic [ValW-1:0]  out_value_q;
  logic             out_vv_q;
  logic [CntW-1:0]  out_held_q;

  logic [RW-1:0]   wr_ext, rd_ext, held, size_new;
  logic [IW-1:0]   wr_nxt, rd_nxt, look_addr, raddr;
  logic [SW-1:0]   sum;
  logic            look_ok, ram_we;
  logic [7:0]      ram_wdata, rdata, cap_byte;
  logic [ValW-1:0] res_value;
  logic            res_vv;

  // held = write minus read, modulo ring size
  always_comb begin
    wr_ext = RW'(wr_idx_q);
    rd_ext = RW'(rd_idx_q);
    held   = (wr_ext < rd_ext) ? size_q + wr_ext - rd_ext : wr_ext - rd_ext;
  end

  assign wr_nxt = (wr_ext + RW'(1) >= size_q) ? '0 : wr_idx_q + IW'(1);
  assign rd_nxt = (rd_ext + RW'(1) >= size_q) ? '0 : rd_idx_q + IW'(1);

  // window byte address; only meaningful when look_ok
  always_comb begin
    look_ok   = CW'(pos_q) < CW'(held);
    sum       = SW'(rd_idx_q) + SW'(pos_q);
    look_addr = (sum >= SW'(size_q)) ? IW'(sum - SW'(size_q)) : IW'(sum);
  end

  always_comb begin
    if (cfg_wdata_i == '0) begin
      size_new = RW'(1);
    end else if (int'(cfg_wdata_i) > STORE_DEPTH) begin
      size_new = RW'(STORE_DEPTH);
    end else begin
      size_new = RW'(cfg_wdata_i);
    end
  end

  assign ram_we    = ctl_i.wr_hi | ctl_i.wr_lo;
  assign ram_wdata = ctl_i.wr_hi ? data_q[15:8] : data_q[7:0];
  assign raddr     = ctl_i.pop_rd ? rd_idx_q : look_addr;

  brb_ram #(
    .Width (8),
    .Depth (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      size_q      <= RW'(ResetSize);
      pend_q      <= 1'b0;
      rng_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q   <= size_new;
        wr_idx_q <= '0;
        rd_idx_q <= '0;
      end else if (ctl_i.clear) begin
        wr_idx_q <= '0;
        rd_idx_q <= '0;
      end else begin
        if (ram_we) begin
          wr_idx_q <= wr_nxt;
        end
        if (ctl_i.pop_rd) begin
          rd_idx_q <= rd_nxt;
        end
      end
      pend_q <= ctl_i.pop_rd | ctl_i.look_rd;
      rng_q  <= ctl_i.pop_rd | (ctl_i.look_rd & look_ok);
      if (ctl_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cap_byte = rng_q ? rdata : 8'h00;

  always_comb begin
    unique case (op_q)
      OP_POP8, OP_POP16, OP_POP32: begin
        res_value = acc_q;
        res_vv    = 1'b1;
      end
      OP_PEEK: begin
        res_value = acc_q;
        res_vv    = pk_ok_q;
      end
      OP_CRC: begin
        res_value = {16'h0000, crc_q};
        res_vv    = 1'b1;
      end
      OP_PUT8, OP_PUT16, OP_CLEAR: begin
        res_value = '0;
        res_vv    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q   <= op_e'(op_i);
      data_q <= data_i;
      acc_q  <= '0;
      crc_q  <= crc_seed_i;
      if (op_e'(op_i) == OP_PEEK) begin
        pos_q <= PosW'(offset_i);
        cnt_q <= LenW'(1);
      end else begin
        // CRC walks from the window's last byte down
        pos_q <= PosW'(offset_i) + PosW'(length_i) - PosW'(1);
        cnt_q <= length_i;
      end
    end else begin
      if (ctl_i.look_rd) begin
        pos_q <= pos_q - PosW'(1);
        cnt_q <= cnt_q - LenW'(1);
      end
      if (pend_q) begin
        if (op_q == OP_CRC) begin
          crc_q <= crc_step(crc_q, rng_q ? rdata : PadByte);
        end else begin
          acc_q <= {acc_q[ValW-9:0], cap_byte};
        end
        pk_ok_q <= rng_q;
      end
    end
    if (ctl_i.finish) begin
      out_value_q <= res_value;
      out_vv_q    <= res_vv;
      out_held_q  <= CntW'(held);
    end
  end

  assign sts_o.last_look = (cnt_q == LenW'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign value_valid_o = out_vv_q;
  assign held_count_o  = out_held_q;

endmodule

>>> src/brb_checker.sv
module brb_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [brb_pkg::ValW-1:0] value_i,
  input logic                     value_valid_i,
  input logic [brb_pkg::CntW-1:0] held_count_i
);
  import brb_pkg::*;

  // words accepted whose result has not been taken yet
  logic [1:0] outst_q, outst_d;

  always_comb begin
    outst_d = outst_q;
    if (in_valid_i && in_ready_i) begin
      outst_d = outst_d + 2'd1;
    end
    if (out_valid_i && out_ready_i) begin
      outst_d = outst_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_i)
      && $stable(value_valid_i) && $stable(held_count_i))
    else $error("result changed while stalled");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> outst_q != 2'd0)
    else $error("result without an accepted word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q == 2'd2 && !out_ready_i |-> !in_ready_i)
    else $error("word taken with work and output both full");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> outst_q != 2'd3)
    else $error("too many words in flight");

  a_void_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !value_valid_i |-> value_i == '0)
    else $error("nonzero value flagged invalid");

endmodule

bind byte_ring_buffer_with_crc brb_checker u_brb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .value_i       (out_o.value),
  .value_valid_i (out_o.value_valid),
  .held_count_i  (out_o.held_count)
);

>>> bench/tb_byte_ring_buffer_with_crc.sv
module tb_byte_ring_buffer_with_crc;
  import brb_pkg::*;

  // Test bench for the byte ring buffer. A shadow copy of the ring (store,
  // indices, size) is updated as each input word is accepted. It queues the
  // result word that the block should return, and returned words are checked
  // in order. Stimulus is a short hand-picked sequence, then random phases
  // with different idle patterns and ring sizes, and a phase where the output
  // side holds off long enough to back the block up.

  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam int          StallLimit = 5000;  // cycles with no word moving
  localparam int          ReportMax  = 10;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            value_valid;
    logic [CntW-1:0] held_count;
  } ring_result_t;

  // Shadow of the ring: predicts one result word per accepted input word.
  class ring_shadow;
    logic [7:0]   store [1024];
    bit           written [1024];
    int unsigned  wr_idx;
    int unsigned  rd_idx;
    int unsigned  ring_size;
    ring_result_t results_due[$];
    int unsigned  mismatches;

    function new();
      foreach (written[i]) begin
        written[i] = 1'b0;
        store[i]   = 8'h00;
      end
      wr_idx     = 0;
      rd_idx     = 0;
      ring_size  = 1024;
      mismatches = 0;
    endfunction

    // Size write: clamped to 1..1024, and both indices go to zero.
    function void set_size(int unsigned v);
      ring_size = (v == 0) ? 1 : (v > 1024) ? 1024 : v;
      wr_idx    = 0;
      rd_idx    = 0;
    endfunction

    function int unsigned held();
      return (wr_idx < rd_idx) ? ring_size + wr_idx - rd_idx : wr_idx - rd_idx;
    endfunction

    // Slot at distance pos (< held) from the read index.
    function int unsigned slot(int unsigned pos);
      int unsigned p;
      p = rd_idx + pos;
      return (p >= ring_size) ? p - ring_size : p;
    endfunction

    function int unsigned pop_width(op_e op);
      case (op)
        OP_POP8:  return 1;
        OP_POP16: return 2;
        OP_POP32: return 4;
        default:  return 0;
      endcase
    endfunction

    function void put(logic [7:0] b);
      store[wr_idx]   = b;
      written[wr_idx] = 1'b1;
      wr_idx++;
      if (wr_idx >= ring_size) wr_idx = 0;
    endfunction

    function logic [7:0] pop();
      logic [7:0] b;
      b = store[rd_idx];
      rd_idx++;
      if (rd_idx >= ring_size) rd_idx = 0;
      return b;
    endfunction

    function bit look(int unsigned pos, output logic [7:0] b);
      b = 8'h00;
      if (pos >= held()) return 1'b0;
      b = store[slot(pos)];
      return 1'b1;
    endfunction

    // Bitwise CRC-16, walking the window from its last byte to its first.
    function logic [15:0] window_crc(int unsigned start, int unsigned len, logic [15:0] seed);
      logic [15:0] c;
      logic [7:0]  b;
      c = seed;
      for (int unsigned i = len; i > 0; i--) begin
        if (!look(start + i - 1, b)) b = PadByte;
        c = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
          c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
        end
      end
      return c;
    endfunction

    // True if the word would read a store entry that was never written.
    function bit reads_blank(op_e op, int unsigned off, int unsigned len);
      int unsigned p;
      int unsigned h;
      h = held();
      p = rd_idx;
      for (int unsigned i = 0; i < pop_width(op); i++) begin
        if (!written[p]) return 1'b1;
        p++;
        if (p >= ring_size) p = 0;
      end
      if (op == OP_PEEK && off < h) return !written[slot(off)];
      if (op == OP_CRC) begin
        for (int unsigned pos = off; pos < off + len && pos < h; pos++) begin
          if (!written[slot(pos)]) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_word(op_e op, logic [15:0] data, logic [9:0] off,
                            logic [10:0] len, logic [15:0] seed);
      ring_result_t r;
      logic [7:0]   b;
      r = '0;
      case (op)
        OP_PUT8:  put(data[7:0]);
        OP_PUT16: begin
          put(data[15:8]);
          put(data[7:0]);
        end
        OP_POP8: begin
          r.value[7:0]  = pop();
          r.value_valid = 1'b1;
        end
        OP_POP16: begin
          r.value[15:8] = pop();
          r.value[7:0]  = pop();
          r.value_valid = 1'b1;
        end
        OP_POP32: begin
          r.value[31:24] = pop();
          r.value[23:16] = pop();
          r.value[15:8]  = pop();
          r.value[7:0]   = pop();
          r.value_valid  = 1'b1;
        end
        OP_PEEK: begin
          if (look(off, b)) begin
            r.value[7:0]  = b;
            r.value_valid = 1'b1;
          end
        end
        OP_CRC: begin
          r.value[15:0] = window_crc(off, len, seed);
          r.value_valid = 1'b1;
        end
        default: begin
          wr_idx = 0;
          rd_idx = 0;
        end
      endcase
      r.held_count = CntW'(held());
      results_due.push_back(r);
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result word: value %h valid %b count %0d",
                   got.value, got.value_valid, got.held_count);
        return;
      end
      want = results_due.pop_front();
      if (got.value !== want.value || got.value_valid !== want.value_valid ||
          got.held_count !== want.held_count) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("result mismatch: value %h/%h valid %b/%b count %0d/%0d (exp/got)",
                   want.value, got.value, want.value_valid, got.value_valid,
                   want.held_count, got.held_count);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SizeW-1:0]  cfg_wdata_i;

  brb_in_if  in_bus ();
  brb_out_if out_bus ();

  ring_shadow  shadow = new();
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left     = 0;  // forced output hold-off, in cycles

  byte_ring_buffer_with_crc dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always #2 clk_i = ~clk_i;

  // Offer one word at a falling edge, after a random idle gap, and hold it
  // until a rising edge sees ready. Valid stays high on return so that the
  // next word can follow back to back; quiet_input drops it.
  task automatic send_word(op_e op, logic [15:0] data, logic [9:0] off,
                           logic [10:0] len, logic [15:0] seed);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.op       <= op;
    in_bus.data     <= data;
    in_bus.offset   <= off;
    in_bus.length   <= len;
    in_bus.crc_seed <= seed;
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
    shadow.note_word(op, data, off, len, seed);
  endtask

  task automatic quiet_input();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
  endtask

  // Size writes only with the block idle: every result back, then a pause.
  task automatic set_ring_size(logic [SizeW-1:0] v);
    quiet_input();
    while (shadow.results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow.set_size(v);
  endtask

  // Random word. Pops mostly find bytes held, peeks and CRC windows mostly
  // start at or below the held count, and anything that would read a
  // never-written store entry turns into a put.
  task automatic random_word();
    op_e         op;
    logic [15:0] data;
    logic [15:0] seed;
    logic [9:0]  off;
    logic [10:0] len;
    int unsigned h;
    int unsigned r;
    h    = shadow.held();
    r    = $urandom_range(0, 99);
    data = 16'($urandom);
    seed = 16'($urandom);
    off  = 10'($urandom);
    len  = 11'($urandom_range(0, 1024));
    if (r < 22)      op = OP_PUT8;
    else if (r < 44) op = OP_PUT16;
    else if (r < 56) op = OP_POP8;
    else if (r < 64) op = OP_POP16;
    else if (r < 72) op = OP_POP32;
    else if (r < 84) op = OP_PEEK;
    else if (r < 96) op = OP_CRC;
    else             op = OP_CLEAR;
    if (op == OP_PEEK && $urandom_range(0, 3) != 0) off = 10'($urandom_range(0, h));
    if (op == OP_CRC) begin
      if ($urandom_range(0, 9) != 0) off = 10'($urandom_range(0, h));
      // long windows are slow: only now and then
      if ($urandom_range(0, 19) != 0) len = 11'($urandom_range(0, 16));
    end
    if (h < shadow.pop_width(op) && $urandom_range(0, 4) != 0) op = OP_PUT16;
    if (shadow.reads_blank(op, off, len)) op = OP_PUT16;
    send_word(op, data, off, len, seed);
  endtask

  task automatic run_phase(int unsigned words, int unsigned src_pct, int unsigned snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    repeat (words) random_word();
    quiet_input();
  endtask

  // Hand-picked words: field extremes, every op, peek at and past the count,
  // empty and over-long CRC windows, pop from an empty ring, and the size
  // clamps at both ends.
  task automatic directed_words();
    send_word(OP_PUT8,  16'hFF5A, '0, '0, '0);
    send_word(OP_PUT16, 16'hFFFF, '1, '1, '1);
    send_word(OP_PUT16, 16'h0000, '0, '0, '0);
    send_word(OP_PUT8,  16'h0000, '0, '0, '0);
    send_word(OP_PUT16, 16'h1234, '0, '0, '0);
    send_word(OP_PEEK,  '0, 10'd0,    '0, '0);
    send_word(OP_PEEK,  '0, 10'd7,    '0, '0);
    send_word(OP_PEEK,  '0, 10'd8,    '0, '0);  // at the count: invalid
    send_word(OP_PEEK,  '0, 10'd1023, '0, '0);
    send_word(OP_CRC,   '0, 10'd0,    11'd8,    16'hFFFF);
    send_word(OP_CRC,   '0, 10'd0,    11'd0,    16'h0000);
    send_word(OP_CRC,   '0, 10'd1023, 11'd1024, 16'h1D0F);  // all padding
    send_word(OP_CRC,   '0, 10'd5,    11'd1024, 16'hFFFF);
    send_word(OP_POP8,  '0, '0, '0, '0);
    send_word(OP_POP16, '0, '0, '0, '0);
    send_word(OP_POP32, '0, '0, '0, '0);
    send_word(OP_CLEAR, '1, '1, '1, '1);
    // empty pop: slot 0 holds data, count wraps to size - 1
    send_word(OP_POP8,  '0, '0, '0, '0);
    send_word(OP_PEEK,  '0, 10'd3, '0, '0);
    send_word(OP_CRC,   '0, 10'd0, 11'd3, 16'h0000);
    send_word(OP_CLEAR, '0, '0, '0, '0);
    set_ring_size(11'd0);  // clamps to one byte: always reads as empty
    send_word(OP_PUT16, 16'hBEEF, '0, '0, '0);
    send_word(OP_POP8,  '0, '0, '0, '0);
    send_word(OP_PEEK,  '0, 10'd0, '0, '0);
    send_word(OP_CRC,   '0, 10'd0, 11'd1, 16'hFFFF);
    set_ring_size(11'd2047);  // clamps to the full store
  endtask

  // Output side: random stalls, or a forced hold-off when hold_left is set.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      shadow.check_result('{out_bus.value, out_bus.value_valid, out_bus.held_count});
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("byte_ring_buffer_with_crc test failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_bus.valid    = 1'b0;
    in_bus.op       = OP_PUT8;
    in_bus.data     = '0;
    in_bus.offset   = '0;
    in_bus.length   = '0;
    in_bus.crc_seed = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_words();
    run_phase(110, 0, 0);
    set_ring_size(11'd7);
    run_phase(110, 84, 0);
    set_ring_size(11'd300);
    run_phase(110, 0, 84);
    set_ring_size(11'd1);
    run_phase(80, 38, 38);
    set_ring_size(11'd2);
    run_phase(60, 38, 38);
    // Back-pressure: output held off while words keep coming.
    set_ring_size(11'd1024);
    hold_left = 300;
    run_phase(80, 0, 0);

    snk_stall_pct = 0;
    while (shadow.results_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.results_due.size() == 0) begin
      $display("byte_ring_buffer_with_crc test passed");
    end else begin
      $display("byte_ring_buffer_with_crc test failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/brb_pkg.sv
src/brb_in_if.sv
src/brb_out_if.sv
src/brb_ram.sv
src/brb_ctrl.sv
src/brb_dp.sv
src/byte_ring_buffer_with_crc.sv
src/brb_checker.sv
bench/tb_byte_ring_buffer_with_crc.sv
